/* hdl/gbfa_pkg.sv */
// ----------------------------------------------------------------------------
// gbfa_pkg
// Shared types and constants for the GB2312 font ROM address stream.
// ----------------------------------------------------------------------------
package gbfa_pkg;

  localparam logic [1:0] KIND_16X16 = 2'd0;
  localparam logic [1:0] KIND_8X16  = 2'd1;
  localparam logic [1:0] KIND_5X8   = 2'd2;

  localparam logic [7:0] LEAD_HZ_LO   = 8'hB0;
  localparam logic [7:0] LEAD_HZ_HI   = 8'hF7;
  localparam logic [7:0] LEAD_SYM_LO  = 8'hA1;
  localparam logic [7:0] LEAD_SYM_HI  = 8'hA3;
  localparam logic [7:0] TRAIL_LO     = 8'hA1;
  localparam logic [7:0] ASCII_LO     = 8'h20;
  localparam logic [7:0] ASCII_HI     = 8'h7E;
  localparam logic [6:0] ROW_SIZE     = 7'd94;
  localparam logic [9:0] HZ_BASE_ROW  = 10'd846;
  localparam logic [23:0] ASCII16_BASE = 24'h03CF80;
  localparam logic [23:0] ASCII8_BASE  = 24'h03BFC0;

  localparam logic [7:0] ADV_16X16 = 8'd16;
  localparam logic [7:0] ADV_8X16  = 8'd8;
  localparam logic [7:0] ADV_5X8   = 8'd6;

  typedef struct packed {
    logic [7:0] held_lead_byte;
    logic       lead_pending;
    logic [7:0] cursor_column;
    logic [3:0] cursor_page;
    logic       string_ended;
  } dec_state_t;

  typedef struct packed {
    logic [23:0] font_address;
    logic [1:0]  glyph_kind;
    logic [3:0]  glyph_page;
    logic [7:0]  glyph_column;
  } glyph_word_t;

endpackage

/* hdl/gbfa_decode.sv */
// ----------------------------------------------------------------------------
// gbfa_decode
// Byte classifier, lead/trail pairing and font ROM address generation.
// ----------------------------------------------------------------------------
module gbfa_decode import gbfa_pkg::*; (
  input  logic        font_mode,
  input  logic [7:0]  text_byte,
  input  logic        string_start,
  input  logic [3:0]  start_page,
  input  logic [7:0]  start_column,
  input  dec_state_t  state_cur,
  output dec_state_t  state_next,
  output logic        emit,
  output glyph_word_t word
);

  logic        is_ascii;
  logic        is_lead;
  logic        lead_hz;
  logic [6:0]  row;
  logic [12:0] row_off;
  logic [6:0]  trail_off;
  logic [13:0] hz_index;
  logic [23:0] addr_16x16;
  logic [23:0] addr_8x16;
  logic [23:0] addr_5x8;
  logic [6:0]  ascii_off;
  logic [7:0]  adv;
  dec_state_t  s;

  assign is_ascii = (text_byte >= ASCII_LO) && (text_byte <= ASCII_HI);
  assign is_lead  = ((text_byte >= LEAD_HZ_LO) && (text_byte <= LEAD_HZ_HI)) ||
                    ((text_byte >= LEAD_SYM_LO) && (text_byte <= LEAD_SYM_HI));

  assign lead_hz   = state_cur.held_lead_byte >= LEAD_HZ_LO;
  assign row       = lead_hz ? 7'(state_cur.held_lead_byte - LEAD_HZ_LO)
                             : 7'(state_cur.held_lead_byte - LEAD_SYM_LO);
  assign row_off   = {6'd0, row} * {6'd0, ROW_SIZE};
  assign trail_off = 7'(text_byte - TRAIL_LO);
  assign hz_index  = 14'(row_off) + 14'(trail_off) +
                     (lead_hz ? 14'(HZ_BASE_ROW) : 14'd0);
  assign addr_16x16 = {5'd0, hz_index, 5'd0};

  assign ascii_off = 7'(text_byte - ASCII_LO);
  assign addr_8x16 = ASCII16_BASE + {13'd0, ascii_off, 4'd0};
  assign addr_5x8  = ASCII8_BASE + {14'd0, ascii_off, 3'd0};

  always_comb begin
    s = state_cur;
    if (string_start) begin
      s.cursor_page   = start_page;
      s.cursor_column = start_column;
      s.string_ended  = 1'b0;
      s.lead_pending  = 1'b0;
    end
    emit              = 1'b0;
    adv               = ADV_8X16;
    word.font_address = addr_8x16;
    word.glyph_kind   = KIND_8X16;
    word.glyph_page   = s.cursor_page;
    word.glyph_column = s.cursor_column;
    state_next        = s;

    if (!s.string_ended) begin
      if (font_mode) begin
        state_next.lead_pending = 1'b0;
        if (text_byte == 8'd0) begin
          state_next.string_ended = 1'b1;
        end else if (is_ascii) begin
          emit              = 1'b1;
          adv               = ADV_5X8;
          word.font_address = addr_5x8;
          word.glyph_kind   = KIND_5X8;
        end
      end else if (s.lead_pending && (text_byte >= TRAIL_LO)) begin
        state_next.lead_pending = 1'b0;
        emit              = 1'b1;
        adv               = ADV_16X16;
        word.font_address = addr_16x16;
        word.glyph_kind   = KIND_16X16;
      end else begin
        // bad trail falls through and the byte is judged afresh
        state_next.lead_pending = 1'b0;
        if (text_byte == 8'd0) begin
          state_next.string_ended = 1'b1;
        end else if (is_lead) begin
          state_next.held_lead_byte = text_byte;
          state_next.lead_pending   = 1'b1;
        end else if (is_ascii) begin
          emit = 1'b1;
        end
      end
    end

    if (emit) begin
      state_next.cursor_column = s.cursor_column + adv;
    end
  end

endmodule

/* hdl/gb2312_font_rom_address_stream_core.sv */
// ----------------------------------------------------------------------------
// gb2312_font_rom_address_stream_core
// Text byte stream in, one glyph fetch request out per recognized character.
// ----------------------------------------------------------------------------
// Glyph words are registered in the output stage, or in the one-word skid
//   stage while the output stalls. Throughput: 1 byte per cycle while
//   text_stall is low; decode is one pass from handshake to output register.
// Reset: synchronous, active high; font_mode = 0, no string open, cursor
//   and held lead byte cleared, output and skid stages empty.
// ----------------------------------------------------------------------------
module gb2312_font_rom_address_stream_core import gbfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        string_start,
  input  logic [3:0]  start_page,
  input  logic [7:0]  start_column,
  output logic        glyph_valid,
  input  logic        glyph_stall,
  output logic [23:0] font_address,
  output logic [1:0]  glyph_kind,
  output logic [3:0]  glyph_page,
  output logic [7:0]  glyph_column
);

  logic        font_mode;
  dec_state_t  state_cur;
  dec_state_t  state_next;
  logic        emit;
  glyph_word_t word;
  glyph_word_t out_word;
  glyph_word_t skid_word;
  logic        out_full;
  logic        skid_full;
  logic        take;
  logic        out_free;

  gbfa_decode u_decode (
    .font_mode    (font_mode),
    .text_byte    (text_byte),
    .string_start (string_start),
    .start_page   (start_page),
    .start_column (start_column),
    .state_cur    (state_cur),
    .state_next   (state_next),
    .emit         (emit),
    .word         (word)
  );

  assign text_stall   = skid_full;
  assign take         = text_valid && !skid_full;
  assign out_free     = !out_full || !glyph_stall;
  assign glyph_valid  = out_full;
  assign font_address = out_word.font_address;
  assign glyph_kind   = out_word.glyph_kind;
  assign glyph_page   = out_word.glyph_page;
  assign glyph_column = out_word.glyph_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_mode <= 1'b0;
    end else if (cfg_we) begin
      font_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_cur <= '{held_lead_byte: 8'd0, lead_pending: 1'b0, cursor_column: 8'd0,
                     cursor_page: 4'd0, string_ended: 1'b1};
    end else if (take) begin
      state_cur <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_free) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (take && emit) begin
      if (out_free) begin
        out_full <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_free) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_free) begin
        out_word <= skid_word;
      end
    end else if (take && emit) begin
      if (out_free) begin
        out_word <= word;
      end else begin
        skid_word <= word;
      end
    end
  end

endmodule
